[hw/rtl/rth_pkg.sv]
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the RGB to HSV converter
// Channel and hue widths, hue angle constants, sector codes and the sideband
// record that rides through the divider pipeline next to the hue quotient.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int CHAN_W    = 8;      // one color channel
  localparam int HUE_W     = 15;     // hue in 1/64 degree
  localparam int HUE_SIXTH = 3840;   // 60 degrees
  localparam int HUE_TURN  = 23040;  // 360 degrees
  localparam int HNUM_W    = 20;     // 3840 * 255 fits in 20 bits
  localparam int SNUM_W    = 16;     // 255 * 255 fits in 16 bits
  localparam int QUO_W     = 12;     // hue quotient reaches 3840

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  typedef struct packed {
    logic              gray;    // delta is zero
    logic              neg;     // channel difference is negative
    sector_t           sector;
    logic [CHAN_W-1:0] bright;
  } hue_side_t;

  function automatic logic [HUE_W-1:0] sector_base(sector_t sec);
    logic [HUE_W-1:0] base;
    case (sec)
      SECTOR_RED:   base = '0;
      SECTOR_GREEN: base = HUE_W'(2 * HUE_SIXTH);
      SECTOR_BLUE:  base = HUE_W'(4 * HUE_SIXTH);
      default:      base = '0;
    endcase
    return base;
  endfunction

endpackage

[hw/rtl/rgb_to_hsv_converter_core.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core: streaming RGB to HSV pixel converter
// Turns one 8-bit RGB pixel into hue (1/64 degree), saturation and value.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while the output is not stalled, and
// returns the results in order, one result per pixel. The latency comes
// from two front stages (max/min/sector, then scaling of the numerators),
// twelve stages of the restoring divider that produces one quotient bit per
// stage for hue and saturation side by side, and the output register where
// the hue is folded onto its sector base. The pipeline moves as a whole: it
// holds whenever a result sits at the output and the receiver stalls, so
// rgb_stall is high exactly then; bubbles travel through and are not
// squeezed out. Value is the largest channel, saturation is
// floor(255*delta/max), and hue is base + 3840*diff/delta truncated toward
// zero, wrapped into 0..23039. Ties on the largest channel favor red, then
// green, then blue. A gray pixel gives hue 0 and saturation 0. There is no
// configuration and no internal state beyond the pipeline.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rgb_valid,
  output logic                           rgb_stall,
  input  logic [rth_pkg::CHAN_W-1:0]     red,
  input  logic [rth_pkg::CHAN_W-1:0]     green,
  input  logic [rth_pkg::CHAN_W-1:0]     blue,
  output logic                           hsv_valid,
  input  logic                           hsv_stall,
  output logic [rth_pkg::HUE_W-1:0]      hue,
  output logic [rth_pkg::CHAN_W-1:0]     saturation,
  output logic [rth_pkg::CHAN_W-1:0]     brightness
);

  localparam int CW    = rth_pkg::CHAN_W;
  localparam int HW    = rth_pkg::HUE_W;
  localparam int QW    = rth_pkg::QUO_W;
  localparam int SIDEW = $bits(rth_pkg::hue_side_t);
  localparam int DEPTH = 2 + QW + 1;

  // Whole-pipeline advance: hold everything while the output is stalled.
  logic adv;
  logic [DEPTH-1:0] vld;

  assign adv       = ~(vld[DEPTH-1] & hsv_stall);
  assign rgb_stall = ~adv;
  assign hsv_valid = vld[DEPTH-1];

  // Valid bits travel with the data, one per stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], rgb_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pick the largest channel and its sector, the smallest channel,
  // and the signed channel difference for the hue.
  // --------------------------------------------------------------------------
  rth_pkg::sector_t sec_c;
  logic [CW-1:0]    hi_c;
  logic [CW-1:0]    lo_c;
  logic signed [CW:0] diff_c;
  logic [CW:0]      diff_abs_c;

  always_comb begin
    if (red >= green && red >= blue) begin
      sec_c  = rth_pkg::SECTOR_RED;
      hi_c   = red;
      diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      sec_c  = rth_pkg::SECTOR_GREEN;
      hi_c   = green;
      diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_c  = rth_pkg::SECTOR_BLUE;
      hi_c   = blue;
      diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
    end

    lo_c = red;
    if (green < lo_c) lo_c = green;
    if (blue < lo_c)  lo_c = blue;

    diff_abs_c = diff_c[CW] ? (CW+1)'(-diff_c) : diff_c;
  end

  rth_pkg::sector_t s1_sec;
  logic [CW-1:0]    s1_hi;
  logic [CW-1:0]    s1_delta;
  logic [CW-1:0]    s1_mag;
  logic             s1_neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sec   <= sec_c;
      s1_hi    <= hi_c;
      s1_delta <= hi_c - lo_c;
      s1_mag   <= diff_abs_c[CW-1:0];
      s1_neg   <= diff_c[CW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale the numerators with shift-and-subtract
  // (3840 = 4096 - 256, 255 = 256 - 1) and build the sideband record.
  // --------------------------------------------------------------------------
  logic [rth_pkg::HNUM_W-1:0] s2_num_h;
  logic [rth_pkg::SNUM_W-1:0] s2_num_s;
  logic [CW-1:0]              s2_delta;
  logic [CW-1:0]              s2_hi;
  rth_pkg::hue_side_t         s2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_num_h       <= (rth_pkg::HNUM_W'(s1_mag) << 12) - (rth_pkg::HNUM_W'(s1_mag) << 8);
      s2_num_s       <= (rth_pkg::SNUM_W'(s1_delta) << 8) - rth_pkg::SNUM_W'(s1_delta);
      s2_delta       <= s1_delta;
      s2_hi          <= s1_hi;
      s2_side.gray   <= (s1_delta == '0);
      s2_side.neg    <= s1_neg;
      s2_side.sector <= s1_sec;
      s2_side.bright <= s1_hi;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3..14: two dividers in lockstep. Hue carries the sideband record;
  // saturation carries only the gray flag, since a gray pixel may have a zero
  // divisor and its quotient must be dropped.
  // --------------------------------------------------------------------------
  logic [QW-1:0]      quo_h;
  logic [QW-1:0]      quo_s;
  logic [SIDEW-1:0]   side_h_bits;
  logic               gray_s;
  rth_pkg::hue_side_t side_h;

  rth_div #(
    .NUM_W  (rth_pkg::HNUM_W),
    .DEN_W  (CW),
    .QUO_W  (QW),
    .SIDE_W (SIDEW)
  ) u_div_hue (
    .clk      (clk),
    .en       (adv),
    .num      (s2_num_h),
    .den      (s2_delta),
    .side_in  (s2_side),
    .quo      (quo_h),
    .side_out (side_h_bits)
  );

  rth_div #(
    .NUM_W  (rth_pkg::SNUM_W),
    .DEN_W  (CW),
    .QUO_W  (QW),
    .SIDE_W (1)
  ) u_div_sat (
    .clk      (clk),
    .en       (adv),
    .num      (s2_num_s),
    .den      (s2_hi),
    .side_in  (s2_side.gray),
    .quo      (quo_s),
    .side_out (gray_s)
  );

  assign side_h = rth_pkg::hue_side_t'(side_h_bits);

  // --------------------------------------------------------------------------
  // Output stage: add or subtract the quotient at the sector base, wrap a
  // negative hue by one full turn, drop both quotients for a gray pixel.
  // --------------------------------------------------------------------------
  logic [HW-1:0] base_c;
  logic [HW:0]   sub_c;
  logic [HW-1:0] hue_next;
  logic [CW-1:0] sat_next;

  always_comb begin
    base_c = rth_pkg::sector_base(side_h.sector);
    sub_c  = {1'b0, base_c} - (HW+1)'(quo_h);
    if (side_h.gray) begin
      hue_next = '0;
    end else if (!side_h.neg) begin
      hue_next = base_c + HW'(quo_h);
    end else if (sub_c[HW]) begin
      hue_next = HW'(sub_c + (HW+1)'(rth_pkg::HUE_TURN));
    end else begin
      hue_next = sub_c[HW-1:0];
    end
    sat_next = gray_s ? '0 : quo_s[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue        <= hue_next;
      saturation <= sat_next;
      brightness <= side_h.bright;
    end
  end

endmodule

[hw/rtl/rth_div.sv]
// ----------------------------------------------------------------------------
// rth_div: pipelined restoring divider
// One quotient bit per register stage, most significant bit first. A sideband
// word travels alongside so the caller can keep item data aligned.
// ----------------------------------------------------------------------------
module rth_div #(
  parameter int NUM_W  = rth_pkg::HNUM_W,
  parameter int DEN_W  = rth_pkg::CHAN_W,
  parameter int QUO_W  = rth_pkg::QUO_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  localparam int TW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic [NUM_W-1:0]  rem_r  [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int BIT = QUO_W - 1 - i;

    logic [NUM_W-1:0]  rem_cur;
    logic [DEN_W-1:0]  den_cur;
    logic [QUO_W-1:0]  quo_cur;
    logic [SIDE_W-1:0] side_cur;
    logic [TW-1:0]     trial;
    logic [QUO_W-1:0]  quo_nxt;

    if (i == 0) begin : g_first
      assign rem_cur  = num;
      assign den_cur  = den;
      assign quo_cur  = '0;
      assign side_cur = side_in;
    end else begin : g_next
      assign rem_cur  = rem_r[i-1];
      assign den_cur  = den_r[i-1];
      assign quo_cur  = quo_r[i-1];
      assign side_cur = side_r[i-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign trial = TW'(rem_cur) - (TW'(den_cur) << BIT);

    // set this stage's quotient bit on top of the bits found so far
    always_comb begin
      quo_nxt      = quo_cur;
      quo_nxt[BIT] = ~trial[TW-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]       <= trial[TW-1] ? rem_cur : trial[NUM_W-1:0];
        den_r[i]       <= den_cur;
        quo_r[i]       <= quo_nxt;
        side_r[i]      <= side_cur;
      end
    end
  end

  assign quo      = quo_r[QUO_W-1];
  assign side_out = side_r[QUO_W-1];

endmodule

[hw/rtl/rth_checker.sv]
// ----------------------------------------------------------------------------
// rth_checker: port-level checks for the RGB to HSV converter
// Watches the top-level ports and is attached by the bind at the end.
// ----------------------------------------------------------------------------
module rth_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rgb_stall,
  input logic                       hsv_valid,
  input logic                       hsv_stall,
  input logic [rth_pkg::HUE_W-1:0]  hue,
  input logic [rth_pkg::CHAN_W-1:0] saturation,
  input logic [rth_pkg::CHAN_W-1:0] brightness
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv_stall |=> hsv_valid && $stable(hue) && $stable(saturation)
      && $stable(brightness))
    else $error("stalled result changed");

  // input side stalls exactly when the output is blocked
  a_stall: assert property (@(posedge clk)
    rgb_stall == (hsv_valid && hsv_stall))
    else $error("input stall does not follow output backpressure");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hue < rth_pkg::HUE_W'(rth_pkg::HUE_TURN))
    else $error("hue out of range");

  // zero saturation means a gray pixel, whose hue is zero
  a_gray: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && saturation == '0 |-> hue == '0)
    else $error("gray pixel with nonzero hue");

  a_sat_bright: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && saturation != '0 |-> brightness != '0)
    else $error("saturation without brightness");

endmodule

bind rgb_to_hsv_converter_core rth_checker u_rth_checker (.*);

[bench/rgb_to_hsv_converter_core_tb.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core_tb: self-checking bench for the RGB to HSV core
// Streams directed corner pixels and about 1100 random pixels through the core.
// Idle and stall patterns on both channels change between phases. Every
// result is checked field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core_tb;

  localparam int N_RANDOM     = 1100;
  localparam int LATENCY      = 15;      // pixel taken to result shown
  localparam int DRAIN_CYCLES = 4 * LATENCY;
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run

  typedef struct packed {
    logic [rth_pkg::CHAN_W-1:0] red;
    logic [rth_pkg::CHAN_W-1:0] green;
    logic [rth_pkg::CHAN_W-1:0] blue;
  } rgb_pixel_t;

  // gray and wrapped only feed the summary; they are never compared
  typedef struct packed {
    logic [rth_pkg::HUE_W-1:0]  hue;
    logic [rth_pkg::CHAN_W-1:0] saturation;
    logic [rth_pkg::CHAN_W-1:0] brightness;
    logic                       gray;
    logic                       wrapped;
  } hsv_pixel_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       rgb_valid = 1'b0;
  logic                       rgb_stall;
  logic [rth_pkg::CHAN_W-1:0] red = '0;
  logic [rth_pkg::CHAN_W-1:0] green = '0;
  logic [rth_pkg::CHAN_W-1:0] blue = '0;
  logic                       hsv_valid;
  logic                       hsv_stall = 1'b0;
  logic [rth_pkg::HUE_W-1:0]  hue;
  logic [rth_pkg::CHAN_W-1:0] saturation;
  logic [rth_pkg::CHAN_W-1:0] brightness;

  // Pixels still to send, and HSV results owed by the core, oldest first.
  rgb_pixel_t rgb_pending[$];
  hsv_pixel_t hsv_due[$];

  logic rgb_took = 1'b0;  // the pixel on the bus was taken at the last edge
  int   n_total = 0;
  int   n_sent = 0;
  int   n_taken = 0;
  int   n_checked = 0;
  int   n_gray = 0;
  int   n_wrapped = 0;
  int   n_held = 0;
  int   cycles = 0;
  int   errors = 0;

  rgb_to_hsv_converter_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .rgb_valid  (rgb_valid),
    .rgb_stall  (rgb_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Fixed-point HSV of one pixel. The largest channel picks the sector, with
  // ties resolved red first, then green, then blue. Hue is the sector base
  // plus a sixth of a turn scaled by diff/span, truncated toward zero; a
  // negative hue (red sector with blue above green) wraps by a full turn.
  function automatic hsv_pixel_t hsv_of(rgb_pixel_t px);
    int               r, g, b;
    int               top, bottom, span, diff, angle;
    rth_pkg::sector_t sec;
    hsv_pixel_t       res;
    r = px.red;
    g = px.green;
    b = px.blue;
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    span = top - bottom;
    if (top == r) begin
      sec  = rth_pkg::SECTOR_RED;
      diff = g - b;
    end else if (top == g) begin
      sec  = rth_pkg::SECTOR_GREEN;
      diff = b - r;
    end else begin
      sec  = rth_pkg::SECTOR_BLUE;
      diff = r - g;
    end
    res = '0;
    res.brightness = rth_pkg::CHAN_W'(top);
    if (span == 0) begin
      // gray or black: hue and saturation stay zero
      res.gray = 1'b1;
    end else begin
      case (sec)
        rth_pkg::SECTOR_RED:   angle = 0;
        rth_pkg::SECTOR_GREEN: angle = 2 * rth_pkg::HUE_SIXTH;
        default:               angle = 4 * rth_pkg::HUE_SIXTH;
      endcase
      angle = angle + (rth_pkg::HUE_SIXTH * diff) / span;
      if (angle < 0) begin
        angle = angle + rth_pkg::HUE_TURN;
        res.wrapped = 1'b1;
      end
      res.hue        = rth_pkg::HUE_W'(angle);
      res.saturation = rth_pkg::CHAN_W'((255 * span) / top);
    end
    return res;
  endfunction

  // Phase by share of pixels sent: receiver sparse first, then sender
  // sparse, then both sides run flat out.
  function automatic int sender_idle_pct();
    if (n_sent < n_total / 3) return 35;
    if (n_sent < (2 * n_total) / 3) return 65;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (n_sent < n_total / 3) return 65;
    if (n_sent < (2 * n_total) / 3) return 35;
    return 0;
  endfunction

  task automatic add_pixel(int r, int g, int b);
    rgb_pixel_t px;
    px.red   = rth_pkg::CHAN_W'(r);
    px.green = rth_pkg::CHAN_W'(g);
    px.blue  = rth_pkg::CHAN_W'(b);
    rgb_pending.push_back(px);
  endtask

  // Driver: change inputs on the falling edge only. Hold the pixel while it
  // is not taken; otherwise advance to the next queued pixel or go idle.
  // Valid is decided without looking at the stall.
  always @(negedge clk) begin
    rgb_pixel_t nxt;
    if (!rst && (!rgb_valid || rgb_took)) begin
      if (rgb_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
        nxt = rgb_pending.pop_front();
        red       <= nxt.red;
        green     <= nxt.green;
        blue      <= nxt.blue;
        rgb_valid <= 1'b1;
        n_sent++;
      end else begin
        rgb_valid <= 1'b0;
      end
    end
    hsv_stall <= ($urandom_range(99) < receiver_stall_pct());
  end

  // Monitor: sample on the rising edge. Check a shown result against the
  // oldest owed one first, then log the pixel taken at this edge.
  always @(posedge clk) begin
    hsv_pixel_t want;
    rgb_pixel_t px;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, hsv_due.size());
      $display("FAIL");
      $finish;
    end else if (rst) begin
      rgb_took <= 1'b0;
    end else begin
      if (hsv_valid && hsv_stall) n_held++;
      if (hsv_valid && !hsv_stall) begin
        if (hsv_due.size() == 0) begin
          $error("result with nothing owed: hue %0d saturation %0d brightness %0d",
                 hue, saturation, brightness);
          errors++;
        end else begin
          want = hsv_due.pop_front();
          n_checked++;
          if (hue !== want.hue) begin
            $error("hue mismatch: expected %0d, got %0d", want.hue, hue);
            errors++;
          end
          if (saturation !== want.saturation) begin
            $error("saturation mismatch: expected %0d, got %0d",
                   want.saturation, saturation);
            errors++;
          end
          if (brightness !== want.brightness) begin
            $error("brightness mismatch: expected %0d, got %0d",
                   want.brightness, brightness);
            errors++;
          end
        end
      end
      rgb_took <= rgb_valid && !rgb_stall;
      if (rgb_valid && !rgb_stall) begin
        px.red   = red;
        px.green = green;
        px.blue  = blue;
        want = hsv_of(px);
        hsv_due.push_back(want);
        n_taken++;
        if (want.gray) n_gray++;
        if (want.wrapped) n_wrapped++;
      end
    end
  end

  initial begin
    int hi, lo, v, pick;
    int chan[3];

    // Directed corners: black, white, gray, primaries and secondaries,
    // every kind of tie on the largest channel, the negative-hue wrap and
    // the smallest nonzero spans.
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(1, 1, 1);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);   // red and green tie: red sector
    add_pixel(0, 255, 255);   // green and blue tie: green sector
    add_pixel(255, 0, 255);   // red and blue tie: red sector, wraps
    add_pixel(255, 0, 1);     // red sector, hue just below a full turn
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 0);
    add_pixel(0, 0, 1);
    add_pixel(255, 254, 254);
    add_pixel(254, 255, 254);
    add_pixel(254, 254, 255);
    add_pixel(255, 128, 0);
    add_pixel(0, 128, 255);
    add_pixel(128, 0, 255);
    add_pixel(170, 85, 170);
    add_pixel(85, 170, 85);
    add_pixel(3, 2, 1);

    // Random pixels, weighted toward ties, grays, tiny spans and the rails.
    repeat (N_RANDOM) begin
      pick = $urandom_range(9);
      case (pick)
        5: begin
          v = $urandom_range(255);
          add_pixel(v, v, v);
        end
        6: begin
          hi = $urandom_range(255);
          chan[0] = hi;
          chan[1] = hi;
          chan[2] = $urandom_range(hi);
          v = $urandom_range(2);    // which channel sits below the tie
          add_pixel(chan[(v + 1) % 3], chan[(v + 2) % 3], chan[v]);
        end
        7: begin
          if ($urandom_range(1)) add_pixel($urandom_range(255, 250),
                                           $urandom_range(255, 250),
                                           $urandom_range(255, 250));
          else add_pixel($urandom_range(5), $urandom_range(5), $urandom_range(5));
        end
        8: begin
          add_pixel($urandom_range(1) * 255, $urandom_range(1) * 255,
                    $urandom_range(1) * 255);
        end
        9: begin
          hi = $urandom_range(255, 1);
          lo = hi - 1;
          add_pixel($urandom_range(1) ? hi : lo, $urandom_range(1) ? hi : lo,
                    $urandom_range(1) ? hi : lo);
        end
        default: begin
          add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
      endcase
    end
    n_total = rgb_pending.size();

    // Hold reset, then release it on a falling edge.
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Drain: every pixel taken and every result seen, then let the pipe
    // settle so a stray extra result would still be caught.
    while (n_taken < n_total || hsv_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (hsv_due.size() != 0) begin
      $error("%0d results never arrived", hsv_due.size());
      errors++;
    end

    $display("converted %0d pixels in %0d cycles under three idle/stall mixes",
             n_checked, cycles);
    $display("  %0d gray pixels, %0d hue wraps, %0d output cycles held by stall",
             n_gray, n_wrapped, n_held);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
